@@ rtl/dsth_pkg.sv @@
// shared types and constants for the dual sample and track-and-hold block
`timescale 1ns / 1ps
package dsth_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TRIG_W     = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE_HOLD = 2'd0,
    MODE_TRACK_HOLD  = 2'd1,
    MODE_HOLD_TRACK  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_A       = 3'd0,
    CFG_MODE_B       = 3'd1,
    CFG_PHASE_STEP_A = 3'd2,
    CFG_PHASE_STEP_B = 3'd3,
    CFG_DUTY_POINT_A = 3'd4,
    CFG_DUTY_POINT_B = 3'd5,
    CFG_TRIG_LOW     = 3'd6,
    CFG_TRIG_HIGH    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    mode_e                 mode;
    logic [CFG_DATA_W-1:0] phase_step;
    logic [CFG_DATA_W-1:0] duty_point;
  } sect_cfg_t;

  localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RST = 32'd194783;
  localparam logic [CFG_DATA_W-1:0] DUTY_POINT_RST = 32'h8000_0000;
  localparam logic [TRIG_W-1:0]     TRIG_LOW_RST   = 16'd512;
  localparam logic [TRIG_W-1:0]     TRIG_HIGH_RST  = 16'd2048;

endpackage

@@ rtl/dsth_lane.sv @@
// one sample lane: held value register loaded on a section update
`timescale 1ns / 1ps
module dsth_lane
  import dsth_pkg::*;
#(
  parameter int unsigned VOLT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [VOLT_WIDTH-1:0] sample_i,
  output logic [VOLT_WIDTH-1:0] held_o
);

  logic [VOLT_WIDTH-1:0] held_q, held_d;

  assign held_d = load_i ? sample_i : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  assign held_o = held_q;

endmodule

@@ rtl/dsth_sect.sv @@
// per-section update decision: schmitt clock qualifier and phase accumulator lfo
`timescale 1ns / 1ps
module dsth_sect
  import dsth_pkg::*;
#(
  parameter int unsigned VOLT_WIDTH  = 16,
  parameter int unsigned PHASE_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  sect_cfg_t                    cfg_i,
  input  logic                         use_clock_i,
  input  logic signed [VOLT_WIDTH-1:0] clock_i,
  input  logic signed [VOLT_WIDTH-1:0] trig_low_i,
  input  logic signed [VOLT_WIDTH-1:0] trig_high_i,
  output logic                         upd_o
);

  logic [PHASE_WIDTH-1:0] phase_q, phase_d;
  logic                   schmitt_q, schmitt_d;
  logic [PHASE_WIDTH-1:0] step_w, duty_w, phase_nx;
  logic [PHASE_WIDTH:0]   sum;
  logic                   wrapped, clk_ge_hi, clk_le_lo;

  if (PHASE_WIDTH > CFG_DATA_W) begin : g_wide
    assign step_w = {{(PHASE_WIDTH-CFG_DATA_W){1'b0}}, cfg_i.phase_step};
    assign duty_w = {{(PHASE_WIDTH-CFG_DATA_W){1'b0}}, cfg_i.duty_point};
  end else begin : g_narrow
    assign step_w = cfg_i.phase_step[PHASE_WIDTH-1:0];
    assign duty_w = cfg_i.duty_point[PHASE_WIDTH-1:0];
  end

  assign sum       = {1'b0, phase_q} + {1'b0, step_w};
  assign wrapped   = sum[PHASE_WIDTH];
  assign phase_nx  = sum[PHASE_WIDTH-1:0];
  assign clk_ge_hi = clock_i >= trig_high_i;
  assign clk_le_lo = clock_i <= trig_low_i;

  always_comb begin
    case (cfg_i.mode)
      MODE_SAMPLE_HOLD: upd_o = use_clock_i ? (!schmitt_q && clk_ge_hi) : wrapped;
      MODE_TRACK_HOLD:  upd_o = use_clock_i ? clk_ge_hi : (phase_nx < duty_w);
      default:          upd_o = use_clock_i ? !clk_ge_hi : (phase_nx >= duty_w);
    endcase
  end

  always_comb begin
    schmitt_d = schmitt_q;
    phase_d   = phase_q;
    if (fire_i) begin
      if (use_clock_i) begin
        if (cfg_i.mode == MODE_SAMPLE_HOLD) begin
          if (schmitt_q && clk_le_lo) begin
            schmitt_d = 1'b0;
          end else if (!schmitt_q && clk_ge_hi) begin
            schmitt_d = 1'b1;
          end
        end
      end else begin
        phase_d = phase_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      schmitt_q <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      schmitt_q <= schmitt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_lfo_idle_on_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && use_clock_i |=> $stable(phase_q))
    else $error("lfo phase moved while a clock drives the section");

  a_no_state_change_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(schmitt_q))
    else $error("section state changed without a beat");

  a_schmitt_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && use_clock_i && cfg_i.mode == MODE_SAMPLE_HOLD && upd_o |=> schmitt_q)
    else $error("schmitt update without rising to high");
`endif

endmodule

@@ rtl/dual_sample_track_hold.sv @@
// top level: config registers, section decision lanes, held lanes and output stage
//
// two sections (a and b) of LANES_PER_SECTION sample lanes each
// input stream: one beat is one sample tick carrying both clock voltages,
// both clock-present flags and every lane sample
// output stream: one beat per input beat with all held values and the
// per-section update flags
// each section updates from its clock (schmitt edge, or level against
// trigger_high) or, with no clock present, from its own phase lfo; section b
// falls back to clock a when clock b is absent
// the output beat is registered and is presented in the cycle after its input beat is accepted
// throughput: 1 beat per cycle while the receiver keeps taking output beats, set by the single output register stage
// s_axis_tready is high while the output register is empty or being drained
// a stalled receiver holds the output beat and blocks new input beats
// reset clears the held values and lfo phases, sets schmitt state high and
// loads the register defaults; no clearing pass is needed
// config writes (cfg_we_i) take effect at once and are meant for idle time
`timescale 1ns / 1ps
module dual_sample_track_hold
  import dsth_pkg::*;
#(
  parameter int unsigned LANES_PER_SECTION = 4,
  parameter int unsigned VOLT_WIDTH        = 16,
  parameter int unsigned PHASE_WIDTH       = 32,
  localparam int unsigned N_LANES   = 2 * LANES_PER_SECTION,
  localparam int unsigned IN_W      = 2 * VOLT_WIDTH + 2 + N_LANES * VOLT_WIDTH,
  localparam int unsigned IN_DATA_W = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W     = N_LANES * VOLT_WIDTH + 2,
  localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // clock_a, clock_b, clock_a_present, clock_b_present, sample_a1.., sample_b1..
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // held_a1.., held_b1.., updated_a, updated_b
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PRES_A_BIT = 2 * VOLT_WIDTH;
  localparam int unsigned PRES_B_BIT = 2 * VOLT_WIDTH + 1;
  localparam int unsigned SMP_LSB    = 2 * VOLT_WIDTH + 2;
  localparam int unsigned UPD_LSB    = N_LANES * VOLT_WIDTH;

  sect_cfg_t         cfg_a_q, cfg_b_q;
  logic [TRIG_W-1:0] trig_low_q, trig_high_q;
  logic signed [VOLT_WIDTH-1:0] trig_low_v, trig_high_v;

  logic        fire;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  upd_q, upd;
  logic        pres_a, pres_b, use_clock_b;
  logic signed [VOLT_WIDTH-1:0] clock_a, clock_b, clock_b_sel;
  logic [N_LANES*VOLT_WIDTH-1:0] held_flat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_a_q     <= '{mode: MODE_SAMPLE_HOLD, phase_step: PHASE_STEP_RST,
                       duty_point: DUTY_POINT_RST};
      cfg_b_q     <= '{mode: MODE_SAMPLE_HOLD, phase_step: PHASE_STEP_RST,
                       duty_point: DUTY_POINT_RST};
      trig_low_q  <= TRIG_LOW_RST;
      trig_high_q <= TRIG_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE_A:       cfg_a_q.mode       <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_MODE_B:       cfg_b_q.mode       <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_PHASE_STEP_A: cfg_a_q.phase_step <= cfg_data_i;
        CFG_PHASE_STEP_B: cfg_b_q.phase_step <= cfg_data_i;
        CFG_DUTY_POINT_A: cfg_a_q.duty_point <= cfg_data_i;
        CFG_DUTY_POINT_B: cfg_b_q.duty_point <= cfg_data_i;
        CFG_TRIG_LOW:     trig_low_q         <= cfg_data_i[TRIG_W-1:0];
        CFG_TRIG_HIGH:    trig_high_q        <= cfg_data_i[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // thresholds seen at the voltage width
  if (VOLT_WIDTH > TRIG_W) begin : g_trig_wide
    assign trig_low_v  = $signed({{(VOLT_WIDTH-TRIG_W){1'b0}}, trig_low_q});
    assign trig_high_v = $signed({{(VOLT_WIDTH-TRIG_W){1'b0}}, trig_high_q});
  end else begin : g_trig_narrow
    assign trig_low_v  = $signed(trig_low_q[VOLT_WIDTH-1:0]);
    assign trig_high_v = $signed(trig_high_q[VOLT_WIDTH-1:0]);
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  assign clock_a     = $signed(s_axis_tdata[0 +: VOLT_WIDTH]);
  assign clock_b     = $signed(s_axis_tdata[VOLT_WIDTH +: VOLT_WIDTH]);
  assign pres_a      = s_axis_tdata[PRES_A_BIT];
  assign pres_b      = s_axis_tdata[PRES_B_BIT];
  assign use_clock_b = pres_a || pres_b;
  assign clock_b_sel = pres_b ? clock_b : clock_a;

  dsth_sect #(
    .VOLT_WIDTH (VOLT_WIDTH),
    .PHASE_WIDTH(PHASE_WIDTH)
  ) u_sect_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cfg_i      (cfg_a_q),
    .use_clock_i(pres_a),
    .clock_i    (clock_a),
    .trig_low_i (trig_low_v),
    .trig_high_i(trig_high_v),
    .upd_o      (upd[0])
  );

  dsth_sect #(
    .VOLT_WIDTH (VOLT_WIDTH),
    .PHASE_WIDTH(PHASE_WIDTH)
  ) u_sect_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cfg_i      (cfg_b_q),
    .use_clock_i(use_clock_b),
    .clock_i    (clock_b_sel),
    .trig_low_i (trig_low_v),
    .trig_high_i(trig_high_v),
    .upd_o      (upd[1])
  );

  for (genvar k = 0; k < N_LANES; k++) begin : g_lane
    dsth_lane #(
      .VOLT_WIDTH(VOLT_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (fire && upd[k >= LANES_PER_SECTION]),
      .sample_i(s_axis_tdata[SMP_LSB + k*VOLT_WIDTH +: VOLT_WIDTH]),
      .held_o  (held_flat[k*VOLT_WIDTH +: VOLT_WIDTH])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= '0;
    end else if (fire) begin
      upd_q <= upd;
    end
  end

  // merge the lanes and the section flags into one beat
  always_comb begin
    m_axis_tdata                 = '0;
    m_axis_tdata[0 +: UPD_LSB]   = held_flat;
    m_axis_tdata[UPD_LSB +: 2]   = upd_q;
  end

  assign m_axis_tvalid = out_valid_q;

`ifndef NO_ASSERTIONS
  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("accepted beat produced no output beat");

  a_held_only_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(held_flat))
    else $error("held values changed without an input beat");

  a_flags_only_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !fire |=> $stable(upd_q))
    else $error("update flags changed under a pending output beat");
`endif

endmodule

@@ tb/tb.sv @@
// testbench for the dual sample and track-and-hold block: predictor, stimulus, checks
`timescale 1ns / 1ps
module tb;
  import dsth_pkg::*;

  localparam int unsigned LANES      = 4;
  localparam int unsigned VW         = 16;
  localparam int unsigned N_LANES    = 2 * LANES;
  localparam int unsigned IN_W       = 2 * VW + 2 + N_LANES * VW;
  localparam int unsigned IN_DATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W      = N_LANES * VW + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned TICKS_PER_PHASE = 75;
  localparam logic [MODE_W-1:0] MODE_THREE = 2'd3;

  // tick fields, msb first: lane samples (a1 lowest), b present, a present, clock b, clock a
  typedef struct packed {
    logic [N_LANES-1:0][VW-1:0] smp;
    logic                       b_present;
    logic                       a_present;
    logic [VW-1:0]              clk_b;
    logic [VW-1:0]              clk_a;
  } tick_t;

  typedef struct packed {
    logic [1:0]                 upd;
    logic [N_LANES-1:0][VW-1:0] held;
  } held_beat_t;

  class held_lane_scoreboard;
    held_beat_t         pending_held[$];
    int                 errors;
    logic [MODE_W-1:0]  mode [2];
    logic [31:0]        step [2];
    logic [31:0]        duty [2];
    logic signed [15:0] trig_lo;
    logic signed [15:0] trig_hi;
    logic [31:0]        phase [2];
    bit                 schmitt_hi [2];
    logic [N_LANES-1:0][VW-1:0] held;

    function new();
      for (int s = 0; s < 2; s++) begin
        mode[s]       = MODE_SAMPLE_HOLD;
        step[s]       = PHASE_STEP_RST;
        duty[s]       = DUTY_POINT_RST;
        phase[s]      = '0;
        schmitt_hi[s] = 1'b1;
      end
      trig_lo = TRIG_LOW_RST;
      trig_hi = TRIG_HIGH_RST;
      held    = '0;
      errors  = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_MODE_A:       mode[0] = v[MODE_W-1:0];
        CFG_MODE_B:       mode[1] = v[MODE_W-1:0];
        CFG_PHASE_STEP_A: step[0] = v;
        CFG_PHASE_STEP_B: step[1] = v;
        CFG_DUTY_POINT_A: duty[0] = v;
        CFG_DUTY_POINT_B: duty[1] = v;
        CFG_TRIG_LOW:     trig_lo = v[15:0];
        CFG_TRIG_HIGH:    trig_hi = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [IN_DATA_W-1:0] d);
      tick_t              t;
      held_beat_t         r;
      logic signed [15:0] clk;
      logic [32:0]        sum;
      bit                 use_clk;
      bit                 upd;
      t = tick_t'(d[$bits(tick_t)-1:0]);
      for (int s = 0; s < 2; s++) begin
        upd     = 1'b0;
        use_clk = (s == 0) ? t.a_present : (t.a_present | t.b_present);
        clk     = (s == 1 && t.b_present) ? t.clk_b : t.clk_a;
        if (use_clk) begin
          case (mode[s])
            MODE_SAMPLE_HOLD: begin
              if (schmitt_hi[s]) begin
                if (clk <= trig_lo) schmitt_hi[s] = 1'b0;
              end else if (clk >= trig_hi) begin
                schmitt_hi[s] = 1'b1;
                upd = 1'b1;
              end
            end
            MODE_TRACK_HOLD: upd = (clk >= trig_hi);
            default:         upd = (clk < trig_hi);
          endcase
        end else begin
          sum      = {1'b0, phase[s]} + {1'b0, step[s]};
          phase[s] = sum[31:0];
          case (mode[s])
            MODE_SAMPLE_HOLD: upd = sum[32];
            MODE_TRACK_HOLD:  upd = (phase[s] < duty[s]);
            default:          upd = (phase[s] >= duty[s]);
          endcase
        end
        if (upd) begin
          for (int j = 0; j < LANES; j++) held[s * LANES + j] = t.smp[s * LANES + j];
        end
        r.upd[s] = upd;
      end
      r.held = held;
      pending_held.push_back(r);
    endfunction

    task check_beat(logic [OUT_DATA_W-1:0] d);
      held_beat_t got;
      held_beat_t want;
      got = held_beat_t'(d[$bits(held_beat_t)-1:0]);
      if (pending_held.size() == 0) begin
        flag_mismatch("output beat with no tick pending");
      end else begin
        want = pending_held.pop_front();
        for (int j = 0; j < N_LANES; j++) begin
          if (got.held[j] !== want.held[j])
            flag_mismatch($sformatf("held_%s%0d got %0d want %0d", (j < LANES) ? "a" : "b",
                                    j % LANES + 1, $signed(got.held[j]),
                                    $signed(want.held[j])));
        end
        if (got.upd[0] !== want.upd[0])
          flag_mismatch($sformatf("updated_a got %0b want %0b", got.upd[0], want.upd[0]));
        if (got.upd[1] !== want.upd[1])
          flag_mismatch($sformatf("updated_b got %0b want %0b", got.upd[1], want.upd[1]));
      end
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  held_lane_scoreboard sb;
  int  cur_lo;
  int  cur_hi;
  bit  send_quiet;
  bit  recv_quiet;
  bit  press_now;
  int  idle_cycles;

  dual_sample_track_hold uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] gen_clock();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $signed($urandom_range(0, 65535) - 32768);
      2:    v = cur_lo;
      3:    v = cur_hi;
      4:    v = cur_hi - 1;
      5:    v = cur_lo + 1;
      6:    v = cur_hi + $urandom_range(0, 500);
      7:    v = cur_lo - $urandom_range(0, 500);
      8:    v = 32767;
      default: v = -32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic tick_t make_tick(logic [15:0] ca, logic [15:0] cb, bit ap, bit bp);
    tick_t t;
    t.clk_a     = ca;
    t.clk_b     = cb;
    t.a_present = ap;
    t.b_present = bp;
    for (int j = 0; j < N_LANES; j++) t.smp[j] = VW'($urandom_range(0, 65535));
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {{(IN_DATA_W - $bits(tick_t)){1'b0}}, t};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_fill(input tick_t t, input logic [15:0] v);
    for (int j = 0; j < N_LANES; j++) t.smp[j] = v;
    send_tick(t);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    if (idx == CFG_TRIG_LOW) cur_lo = $signed(v[15:0]);
    if (idx == CFG_TRIG_HIGH) cur_hi = $signed(v[15:0]);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_held.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_phase();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom() >> 4;
      3:       return 32'h8000_0000 + $urandom_range(0, 1000);
      4:       return $urandom_range(1, 1 << 20);
      default: return $urandom();
    endcase
  endfunction

  task automatic program_section(input int p);
    logic [MODE_W-1:0] ma, mb;
    logic [31:0]       sa, sb_step, da, db;
    int                lo, hi;
    case (p)
      0: begin
        ma = MODE_SAMPLE_HOLD; mb = MODE_SAMPLE_HOLD;
        sa = 32'hFFFF_FFFF; sb_step = 32'hFFFF_FFFF; da = 32'h0; db = 32'h0;
        lo = -32768; hi = 32767;
      end
      1: begin
        ma = MODE_THREE; mb = MODE_THREE;
        sa = 32'h0; sb_step = 32'h0; da = 32'hFFFF_FFFF; db = 32'hFFFF_FFFF;
        lo = 32767; hi = -32768;
      end
      2: begin
        ma = MODE_TRACK_HOLD; mb = MODE_HOLD_TRACK;
        sa = 32'h8000_0000; sb_step = 32'h8000_0000; da = 32'h8000_0000; db = 32'h8000_0000;
        lo = 0; hi = 0;
      end
      default: begin
        ma = MODE_W'($urandom_range(0, 3)); mb = MODE_W'($urandom_range(0, 3));
        sa = pick_phase(); sb_step = pick_phase(); da = pick_phase(); db = pick_phase();
        lo = $urandom_range(0, 8000) - 4000;
        case ($urandom_range(0, 3))
          0:       hi = lo - $urandom_range(0, 1500);
          default: hi = lo + $urandom_range(1, 4000);
        endcase
      end
    endcase
    write_reg(CFG_MODE_A, {{(CFG_DATA_W - MODE_W){1'b0}}, ma});
    write_reg(CFG_MODE_B, {{(CFG_DATA_W - MODE_W){1'b0}}, mb});
    write_reg(CFG_PHASE_STEP_A, sa);
    write_reg(CFG_PHASE_STEP_B, sb_step);
    write_reg(CFG_DUTY_POINT_A, da);
    write_reg(CFG_DUTY_POINT_B, db);
    write_reg(CFG_TRIG_LOW, {16'h0, lo[15:0]});
    write_reg(CFG_TRIG_HIGH, {16'h0, hi[15:0]});
  endtask

  // receiver side ready pattern, with one long hold-off on request
  initial begin
    int stall;
    bit pressed;
    stall   = 0;
    pressed = 1'b0;
    forever begin
      @(negedge clk_i);
      if (press_now && !pressed) begin
        pressed = 1'b1;
        stall   = 150;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (recv_quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        m_axis_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(s_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MODE_A;
    cfg_data_i    = '0;
    cur_lo        = 512;
    cur_hi        = 2048;
    send_quiet    = 1'b0;
    recv_quiet    = 1'b0;
    press_now     = 1'b0;
    idle_cycles   = 0;
    sb            = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: lfo path, schmitt hold between thresholds, fall, rise, clock a fallback
    send_fill(make_tick(16'h0, 16'h0, 1'b0, 1'b0), 16'h0000);
    send_fill(make_tick(16'sd32767, -16'sd32768, 1'b1, 1'b0), 16'h7FFF);
    send_tick(make_tick(16'sd512, 16'h0, 1'b1, 1'b0));
    send_tick(make_tick(16'sd1000, 16'h0, 1'b1, 1'b0));
    send_fill(make_tick(16'sd2048, 16'h0, 1'b1, 1'b0), 16'h8000);
    send_tick(make_tick(-16'sd32768, 16'sd2048, 1'b1, 1'b1));
    send_tick(make_tick(16'sd2047, 16'sd511, 1'b0, 1'b1));
    send_fill(make_tick(16'h0, 16'sd2048, 1'b0, 1'b1), 16'h5555);
    send_fill(make_tick(16'h0, 16'h0, 1'b0, 1'b0), 16'hAAAA);
    wait_idle();

    write_reg(CFG_MODE_A, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_TRACK_HOLD});
    write_reg(CFG_MODE_B, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_HOLD_TRACK});
    send_tick(make_tick(16'sd2048, 16'sd2047, 1'b1, 1'b1));
    send_tick(make_tick(16'sd2047, 16'sd2048, 1'b1, 1'b1));
    send_tick(make_tick(16'h0, 16'h0, 1'b0, 1'b0));
    wait_idle();

    // unnamed mode value, zero step with zero duty point
    write_reg(CFG_MODE_A, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_THREE});
    write_reg(CFG_MODE_B, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_THREE});
    write_reg(CFG_PHASE_STEP_A, 32'h0);
    write_reg(CFG_DUTY_POINT_A, 32'h0);
    send_tick(make_tick(-16'sd32768, 16'sd32767, 1'b1, 1'b1));
    send_tick(make_tick(16'h0, 16'h0, 1'b0, 1'b0));
    wait_idle();

    // crossed thresholds in sample-hold mode
    write_reg(CFG_MODE_A, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_SAMPLE_HOLD});
    write_reg(CFG_MODE_B, {{(CFG_DATA_W - MODE_W){1'b0}}, MODE_SAMPLE_HOLD});
    write_reg(CFG_TRIG_LOW, 32'd3000);
    write_reg(CFG_TRIG_HIGH, 32'd1000);
    send_tick(make_tick(16'sd2000, 16'h0, 1'b1, 1'b0));
    send_tick(make_tick(16'sd2000, 16'h0, 1'b1, 1'b0));
    send_tick(make_tick(16'h0, 16'h0, 1'b0, 1'b0));
    send_tick(make_tick(16'sd32767, -16'sd32768, 1'b1, 1'b1));
    send_tick(make_tick(-16'sd32768, 16'sd32767, 1'b1, 1'b1));
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      program_section(p);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if (p == 4) begin
        send_quiet = 1'b1;
        press_now  = 1'b1;
      end
      for (int k = 0; k < TICKS_PER_PHASE; k++)
        send_tick(make_tick(gen_clock(), gen_clock(), $urandom_range(0, 1),
                            $urandom_range(0, 1)));
      wait_idle();
    end

    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_held.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
